// File: hw/rtl/dnsw2t_pkg.sv
// types, character constants and helpers shared by the name escaper
`timescale 1ns / 1ps

package dnsw2t_pkg;

  localparam logic [7:0] CHR_AT        = 8'h40;
  localparam logic [7:0] CHR_DOLLAR    = 8'h24;
  localparam logic [7:0] CHR_SEMICOLON = 8'h3b;
  localparam logic [7:0] CHR_BACKSLASH = 8'h5c;
  localparam logic [7:0] CHR_DOT       = 8'h2e;
  localparam logic [7:0] COUNT_MAX     = 8'hff;

  typedef struct packed {
    logic [7:0] text_char;
    logic       last;
    logic [7:0] wire_count;
  } result_t;

  // results produced by one accepted wire byte
  typedef struct packed {
    logic [1:0] num;
    result_t    res0;
    result_t    res1;
  } push_t;

  function automatic logic is_special(input logic [7:0] c);
    is_special = (c == CHR_AT) || (c == CHR_DOLLAR) || (c == CHR_SEMICOLON) ||
                 (c == CHR_BACKSLASH) || (c == CHR_DOT);
  endfunction

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    sat_inc = (v == COUNT_MAX) ? v : v + 8'd1;
  endfunction

endpackage

// File: hw/rtl/dnsw2t_decoder.sv
// label/length tracking and character generation for one wire byte
`timescale 1ns / 1ps

module dnsw2t_decoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          wire_byte,
  input  logic                escape_enable,
  output dnsw2t_pkg::push_t   push
);

  logic       at_name_start_r, at_name_start_nxt;
  logic [7:0] label_remaining_r, label_remaining_nxt;
  logic [7:0] byte_count_r, byte_count_nxt;

  always_comb begin
    dnsw2t_pkg::push_t p;
    p                   = '0;
    at_name_start_nxt   = at_name_start_r;
    label_remaining_nxt = label_remaining_r;
    byte_count_nxt      = byte_count_r;
    if (label_remaining_r != 8'd0) begin
      // label content
      byte_count_nxt      = dnsw2t_pkg::sat_inc(byte_count_r);
      label_remaining_nxt = label_remaining_r - 8'd1;
      if (escape_enable && dnsw2t_pkg::is_special(wire_byte)) begin
        p.num                = 2'd2;
        p.res0.text_char     = dnsw2t_pkg::CHR_BACKSLASH;
        p.res1.text_char     = wire_byte;
      end else begin
        p.num                = 2'd1;
        p.res0.text_char     = wire_byte;
      end
    end else if (at_name_start_r) begin
      if (wire_byte == 8'd0) begin
        // root name
        p.num             = 2'd1;
        p.res0.text_char  = dnsw2t_pkg::CHR_DOT;
        p.res0.last       = 1'b1;
        p.res0.wire_count = 8'd1;
        byte_count_nxt    = 8'd0;
      end else begin
        byte_count_nxt      = 8'd1;
        at_name_start_nxt   = 1'b0;
        label_remaining_nxt = wire_byte;
      end
    end else begin
      p.num            = 2'd1;
      p.res0.text_char = dnsw2t_pkg::CHR_DOT;
      if (wire_byte == 8'd0) begin
        p.res0.last       = 1'b1;
        p.res0.wire_count = dnsw2t_pkg::sat_inc(byte_count_r);
        at_name_start_nxt = 1'b1;
        byte_count_nxt    = 8'd0;
      end else begin
        byte_count_nxt      = dnsw2t_pkg::sat_inc(byte_count_r);
        label_remaining_nxt = wire_byte;
      end
    end
    if (!accept) begin
      p.num = 2'd0;
    end
    push = p;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_name_start_r   <= 1'b1;
      label_remaining_r <= 8'd0;
      byte_count_r      <= 8'd0;
    end else if (accept) begin
      at_name_start_r   <= at_name_start_nxt;
      label_remaining_r <= label_remaining_nxt;
      byte_count_r      <= byte_count_nxt;
    end
  end

endmodule

// File: hw/rtl/dnsw2t_out_queue.sv
// three-entry result register queue between the decoder and the output channel
`timescale 1ns / 1ps

module dnsw2t_out_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  dnsw2t_pkg::push_t   push,
  output logic                space,
  output logic                out_valid,
  input  logic                out_ready,
  output dnsw2t_pkg::result_t out_head
);

  localparam int unsigned Depth = 3;

  dnsw2t_pkg::result_t slot_r   [Depth];
  dnsw2t_pkg::result_t slot_nxt [Depth];
  logic [1:0]          cnt_r, cnt_nxt;
  logic                pop;
  logic [1:0]          base;

  assign out_valid = (cnt_r != 2'd0);
  assign out_head  = slot_r[0];
  // room for two more results whatever the output side does this cycle
  assign space     = (cnt_r <= 2'd1);
  assign pop       = out_valid && out_ready;
  assign base      = cnt_r - {1'b0, pop};
  assign cnt_nxt   = base + push.num;

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      if (pop && (i < Depth - 1)) begin
        slot_nxt[i] = slot_r[i + 1];
      end else begin
        slot_nxt[i] = slot_r[i];
      end
      if ((push.num != 2'd0) && (base == 2'(i))) begin
        slot_nxt[i] = push.res0;
      end
      if ((push.num == 2'd2) && (base + 2'd1 == 2'(i))) begin
        slot_nxt[i] = push.res1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < Depth; i++) begin
      slot_r[i] <= slot_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd3)
    else $error("result queue overfilled");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.num != 2'd0) |-> (cnt_r <= 2'd1))
    else $error("results pushed without room");

  a_escape_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (push.num == 2'd2) |-> (push.res0.text_char == dnsw2t_pkg::CHR_BACKSLASH &&
                            !push.res0.last && !push.res1.last))
    else $error("escape pair malformed");

  a_last_dot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_head.last) |-> (out_head.text_char == dnsw2t_pkg::CHR_DOT &&
                                      out_head.wire_count != 8'd0))
    else $error("final result is not a counted dot");
`endif

endmodule

// File: hw/rtl/dns_name_wire_to_text_escaper.sv
// top level: dns name wire form to presentation text with optional escaping
`timescale 1ns / 1ps

// Takes a wire-form DNS name one byte a beat and gives presentation text one
// character a beat. Each wire byte is decoded in the cycle it is accepted and
// its results land in a three-entry output queue, so one byte per cycle flows
// through while the output side takes a character per cycle; a byte that needs
// escaping adds a second character to the output. Input ready depends only on
// the queue fill, never on out_ready. Results are registered in the queue. A
// length byte that opens a name gives no character. The final dot carries last
// and the saturating wire byte count. escape_enable resets to 1 and is written
// through the cfg port, by the user only while idle; not enforced by the block.

module dns_name_wire_to_text_escaper (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_wire_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_text_char,
  output logic       out_last,
  output logic [7:0] out_wire_count,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);

  logic                escape_enable_r;
  logic                accept;
  dnsw2t_pkg::push_t   push;
  dnsw2t_pkg::result_t head;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_enable_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      escape_enable_r <= cfg_data;
    end
  end

  dnsw2t_decoder u_decoder (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .wire_byte     (in_wire_byte),
    .escape_enable (escape_enable_r),
    .push          (push)
  );

  dnsw2t_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_head  (head)
  );

  assign out_text_char  = head.text_char;
  assign out_last       = head.last;
  assign out_wire_count = head.wire_count;

endmodule

// File: tb/tb_dns_name_wire_to_text_escaper.sv
// testbench for the dns name wire to presentation text escaper
`timescale 1ns / 1ps

module tb_dns_name_wire_to_text_escaper;

  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_AT       = 400;
  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 6;
  localparam int IDLE_PCT      = 13;

  localparam logic [7:0] DIRECTED [16] = '{
    8'h00,
    8'h03, dnsw2t_pkg::CHR_AT, dnsw2t_pkg::CHR_DOLLAR, dnsw2t_pkg::CHR_SEMICOLON,
    8'h02, dnsw2t_pkg::CHR_BACKSLASH, dnsw2t_pkg::CHR_DOT, 8'h00,
    8'h02, 8'h00, 8'hff, 8'h00,
    8'h01, 8'h41, 8'h00
  };

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_wire_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_text_char;
  logic       out_last;
  logic [7:0] out_wire_count;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_data;

  // decoder state mirrored by the testbench
  logic       esc_on;
  logic       at_start;
  logic [7:0] lbl_left;
  logic [7:0] name_bytes;

  dnsw2t_pkg::result_t text_due[$];
  logic [7:0]          wire_bytes_pending[$];
  int                  mismatches;
  int                  chars_seen;
  int                  quiet_cycles;
  int                  hold_left;
  bit                  held_off;
  bit                  steady;

  dns_name_wire_to_text_escaper dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_wire_byte  (in_wire_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_text_char (out_text_char),
    .out_last      (out_last),
    .out_wire_count(out_wire_count),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic dnsw2t_pkg::result_t text_beat(input logic [7:0] c, input logic l,
                                                    input logic [7:0] n);
    dnsw2t_pkg::result_t r;
    r.text_char  = c;
    r.last       = l;
    r.wire_count = n;
    return r;
  endfunction

  task automatic bump_name_bytes();
    if (name_bytes != 8'hff) name_bytes = name_bytes + 8'd1;
  endtask

  // works out the text characters one wire byte gives
  task automatic decode_wire_byte(input logic [7:0] b);
    if (lbl_left != 8'd0) begin
      bump_name_bytes();
      lbl_left = lbl_left - 8'd1;
      if (esc_on && (b inside {dnsw2t_pkg::CHR_AT, dnsw2t_pkg::CHR_DOLLAR,
                               dnsw2t_pkg::CHR_SEMICOLON, dnsw2t_pkg::CHR_BACKSLASH,
                               dnsw2t_pkg::CHR_DOT}))
        text_due.push_back(text_beat(dnsw2t_pkg::CHR_BACKSLASH, 1'b0, 8'd0));
      text_due.push_back(text_beat(b, 1'b0, 8'd0));
    end else if (at_start) begin
      name_bytes = 8'd1;
      if (b == 8'd0) begin
        text_due.push_back(text_beat(dnsw2t_pkg::CHR_DOT, 1'b1, name_bytes));
        name_bytes = 8'd0;
      end else begin
        at_start = 1'b0;
        lbl_left = b;
      end
    end else begin
      bump_name_bytes();
      if (b == 8'd0) begin
        text_due.push_back(text_beat(dnsw2t_pkg::CHR_DOT, 1'b1, name_bytes));
        at_start   = 1'b1;
        name_bytes = 8'd0;
      end else begin
        // dot closing the previous label
        text_due.push_back(text_beat(dnsw2t_pkg::CHR_DOT, 1'b0, 8'd0));
        lbl_left = b;
      end
    end
  endtask

  function automatic logic [7:0] label_char();
    logic [7:0] c;
    if ($urandom_range(9) < 3) begin
      case ($urandom_range(4))
        0:       c = dnsw2t_pkg::CHR_AT;
        1:       c = dnsw2t_pkg::CHR_DOLLAR;
        2:       c = dnsw2t_pkg::CHR_SEMICOLON;
        3:       c = dnsw2t_pkg::CHR_BACKSLASH;
        default: c = dnsw2t_pkg::CHR_DOT;
      endcase
    end else begin
      c = 8'($urandom_range(255));
    end
    return c;
  endfunction

  task automatic add_label(input int len);
    wire_bytes_pending.push_back(8'(len));
    repeat (len) wire_bytes_pending.push_back(label_char());
  endtask

  // mostly well-formed names, some runs of loose small bytes
  task automatic queue_random_names(input int budget, input bit with_long);
    int labels;
    if (with_long) begin
      // longest label length, and enough bytes to saturate the count
      add_label(255);
      add_label(60);
      wire_bytes_pending.push_back(8'h00);
    end
    while (wire_bytes_pending.size() < budget) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 6)) wire_bytes_pending.push_back(8'($urandom_range(4)));
      end else begin
        labels = $urandom_range(4);
        repeat (labels)
          add_label(($urandom_range(19) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 8));
        wire_bytes_pending.push_back(8'h00);
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (wire_bytes_pending.size() != 0 || in_valid || text_due.size() != 0);
    // a length byte may still be in flight with nothing to show for it
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_escape(input logic v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    esc_on = v;
    @(negedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) decode_wire_byte(in_wire_byte);
      if (!in_valid || in_ready) begin
        if (wire_bytes_pending.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid     <= 1'b1;
          in_wire_byte <= wire_bytes_pending.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    dnsw2t_pkg::result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        chars_seen++;
        if (text_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected beat, expected none, got char %02h last %0b count %0d",
                   $time, out_text_char, out_last, out_wire_count);
        end else begin
          want = text_due.pop_front();
          if (out_text_char !== want.text_char) begin
            mismatches++;
            $display("%0t: text_char expected %02h got %02h",
                     $time, want.text_char, out_text_char);
          end
          if (out_last !== want.last) begin
            mismatches++;
            $display("%0t: last expected %0b got %0b", $time, want.last, out_last);
          end
          if (out_wire_count !== want.wire_count) begin
            mismatches++;
            $display("%0t: wire_count expected %0d got %0d",
                     $time, want.wire_count, out_wire_count);
          end
        end
      end
      // one long hold-off so the output queue fills and backs up the input
      if (!held_off && chars_seen >= HOLD_AT) begin
        held_off  = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles, %0d characters outstanding",
               $time, STALL_LIMIT, text_due.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_wire_byte = 8'h00;
    out_ready    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data     = 1'b0;
    esc_on       = 1'b1;
    at_start     = 1'b1;
    lbl_left     = 8'd0;
    name_bytes   = 8'd0;
    mismatches   = 0;
    chars_seen   = 0;
    quiet_cycles = 0;
    hold_left    = 0;
    held_off     = 1'b0;
    steady       = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // root, every special character, zero and ff inside a label
    foreach (DIRECTED[i]) wire_bytes_pending.push_back(DIRECTED[i]);
    wait_drained();

    // same specials copied raw
    write_escape(1'b0);
    for (int i = 0; i < 9; i++) wire_bytes_pending.push_back(DIRECTED[i]);
    wait_drained();

    write_escape(1'b1);
    queue_random_names(450, 1'b1);
    wait_drained();

    write_escape(1'b0);
    steady = 1'b1;
    queue_random_names(400, 1'b0);
    wait_drained();
    steady = 1'b0;

    write_escape(1'b1);
    queue_random_names(450, 1'b0);
    wait_drained();

    if (mismatches == 0 && text_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
